// File: design/unescape_string_decoder_assert.svh
// ---------------------------------------------------------------------------
// unescape_string_decoder_assert.svh
// Assertion macros for the escape decoder top level.
// ---------------------------------------------------------------------------
`ifndef UNESCAPE_STRING_DECODER_ASSERT_SVH
`define UNESCAPE_STRING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define USD_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define USD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/usd_pkg.sv
// ---------------------------------------------------------------------------
// usd_pkg
// Shared types for the escaped string decoder.
// ---------------------------------------------------------------------------
package usd_pkg;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_ILLEGAL = 2'd1,
        ERR_TRAIL   = 2'd2,
        ERR_OCTAL   = 2'd3
    } err_t;

    // Work for one input beat: up to two decoded bytes, then an optional status.
    typedef struct packed {
        logic       b0_valid;
        logic [7:0] b0;
        logic       b1_valid;
        logic [7:0] b1;
        logic       st_valid;
        err_t       st_err;
    } usd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } usd_q_status_t;

endpackage

// File: design/usd_if.sv
// ---------------------------------------------------------------------------
// usd_in_if / usd_out_if
// Valid/ready channels for raw bytes in and decoded results out.
// ---------------------------------------------------------------------------
interface usd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in_string;

    modport source (output valid, output in_byte, output last_in_string, input ready);
    modport sink   (input valid, input in_byte, input last_in_string, output ready);
endinterface

interface usd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic [1:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output has_byte, output string_done,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input string_done,
                    input error_code, input last_of_run, output ready);
endinterface

// File: design/usd_front.sv
// ---------------------------------------------------------------------------
// usd_front
// Accept raw bytes, track escape state and build one job per beat.
// ---------------------------------------------------------------------------
module usd_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    usd_in_if.sink                 raw,
    input  usd_pkg::usd_q_status_t q_stat,
    output logic                   push,
    output usd_pkg::usd_job_t      push_job
);

    localparam logic [7:0] BACKSLASH = 8'd92;
    localparam logic [7:0] APOS      = 8'd39;
    localparam logic [7:0] QUOTE     = 8'd34;
    localparam logic [7:0] CH_B      = 8'd98;
    localparam logic [7:0] CH_F      = 8'd102;
    localparam logic [7:0] CH_N      = 8'd110;
    localparam logic [7:0] CH_R      = 8'd114;
    localparam logic [7:0] CH_T      = 8'd116;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [1:0] OCT_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [7:0]   acc_reg, acc_next;
    logic [1:0]   digits_reg, digits_next;
    usd_pkg::err_t err_reg, err_next;

    usd_pkg::usd_job_t job;
    logic        accept;
    logic        is_oct;
    logic        is_print;
    logic        do_plain;
    logic [10:0] oct_val;
    logic [1:0]  digits_inc;

    // Append a decoded byte to the first free byte slot.
    function automatic usd_pkg::usd_job_t put_byte(usd_pkg::usd_job_t j, logic [7:0] v);
        usd_pkg::usd_job_t r;
        r = j;
        if (!r.b0_valid)
        begin
            r.b0_valid = 1'b1;
            r.b0       = v;
        end
        else
        begin
            r.b1_valid = 1'b1;
            r.b1       = v;
        end
        return r;
    endfunction

    assign raw.ready  = !q_stat.full;
    assign accept     = raw.valid && raw.ready;
    assign is_oct     = (raw.in_byte[7:3] == 5'b00110);
    assign is_print   = (raw.in_byte >= PRINT_LO) && (raw.in_byte <= PRINT_HI);
    assign oct_val    = {acc_reg, raw.in_byte[2:0]};
    assign digits_inc = digits_reg + 2'd1;

    always_comb
    begin
        job         = '0;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        err_next    = err_reg;
        do_plain    = 1'b0;

        if (err_reg == usd_pkg::ERR_NONE)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    mode_next = MODE_PLAIN;
                    case (raw.in_byte) inside
                        BACKSLASH, APOS, QUOTE: job = put_byte(job, raw.in_byte);
                        CH_B:    job = put_byte(job, 8'd8);
                        CH_F:    job = put_byte(job, 8'd12);
                        CH_N:    job = put_byte(job, 8'd10);
                        CH_R:    job = put_byte(job, 8'd13);
                        CH_T:    job = put_byte(job, 8'd9);
                        default:
                        begin
                            if (is_oct)
                            begin
                                acc_next    = {5'd0, raw.in_byte[2:0]};
                                digits_next = 2'd1;
                                mode_next   = MODE_OCT;
                            end
                            else if (is_print)
                                job = put_byte(job, raw.in_byte);
                            else
                                err_next = usd_pkg::ERR_ILLEGAL;
                        end
                    endcase
                end
                MODE_OCT:
                begin
                    if (is_oct)
                    begin
                        if (digits_inc == OCT_DIGITS)
                        begin
                            mode_next   = MODE_PLAIN;
                            digits_next = 2'd0;
                            acc_next    = 8'd0;
                            if (oct_val[10:8] != 3'd0)
                                err_next = usd_pkg::ERR_OCTAL;
                            else
                                job = put_byte(job, oct_val[7:0]);
                        end
                        else
                        begin
                            acc_next    = oct_val[7:0];
                            digits_next = digits_inc;
                        end
                    end
                    else
                    begin
                        // run ended early: flush the octal byte, then decode this one
                        job         = put_byte(job, acc_reg);
                        mode_next   = MODE_PLAIN;
                        acc_next    = 8'd0;
                        digits_next = 2'd0;
                        do_plain    = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_PLAIN;
                    do_plain  = 1'b1;
                end
            endcase

            if (do_plain)
            begin
                if (raw.in_byte == BACKSLASH)
                begin
                    if (raw.last_in_string)
                        err_next = usd_pkg::ERR_TRAIL;
                    else
                        mode_next = MODE_ESC;
                end
                else if (is_print)
                    job = put_byte(job, raw.in_byte);
                else
                    err_next = usd_pkg::ERR_ILLEGAL;
            end

            // string closes inside an unfinished octal run
            if (raw.last_in_string && (err_next == usd_pkg::ERR_NONE) && (mode_next == MODE_OCT))
                job = put_byte(job, acc_next);
        end

        if (raw.last_in_string)
        begin
            job.st_valid = 1'b1;
            job.st_err   = err_next;
            mode_next    = MODE_PLAIN;
            acc_next     = 8'd0;
            digits_next  = 2'd0;
            err_next     = usd_pkg::ERR_NONE;
        end
    end

    assign push     = accept && (job.b0_valid || job.st_valid);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            acc_reg    <= 8'd0;
            digits_reg <= 2'd0;
            err_reg    <= usd_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: design/usd_queue.sv
// ---------------------------------------------------------------------------
// usd_queue
// Short job queue between front and back.
// ---------------------------------------------------------------------------
module usd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  usd_pkg::usd_job_t      push_job,
    input  logic                   pop,
    output usd_pkg::usd_job_t      head_job,
    output usd_pkg::usd_q_status_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    usd_pkg::usd_job_t store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: design/usd_back.sv
// ---------------------------------------------------------------------------
// usd_back
// Unpack queued jobs into result beats, one per cycle while the output is not stalled, into an output register.
// ---------------------------------------------------------------------------
module usd_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  usd_pkg::usd_job_t      head_job,
    input  usd_pkg::usd_q_status_t q_stat,
    output logic                   pop,
    usd_out_if.source              decoded
);

    logic [2:0] done_reg, done_next;
    logic [2:0] pending;
    logic [2:0] pick;
    logic       final_pick;
    logic       load;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       sdone_reg, sdone_next;
    logic [1:0] err_reg, err_next;
    logic       lor_reg, lor_next;

    assign load    = !valid_reg || decoded.ready;
    assign pending = q_stat.empty ? 3'b000
                   : ({head_job.st_valid, head_job.b1_valid, head_job.b0_valid} & ~done_reg);

    always_comb
    begin
        if (pending[0])
            pick = 3'b001;
        else if (pending[1])
            pick = 3'b010;
        else if (pending[2])
            pick = 3'b100;
        else
            pick = 3'b000;
        final_pick = ((pending & ~pick) == 3'b000);

        valid_next = valid_reg;
        byte_next  = byte_reg;
        has_next   = has_reg;
        sdone_next = sdone_reg;
        err_next   = err_reg;
        lor_next   = lor_reg;
        done_next  = done_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = (pending != 3'b000);
            byte_next  = 8'd0;
            has_next   = 1'b0;
            sdone_next = 1'b0;
            err_next   = usd_pkg::ERR_NONE;
            lor_next   = final_pick;
            if (pick[0])
            begin
                byte_next = head_job.b0;
                has_next  = 1'b1;
            end
            else if (pick[1])
            begin
                byte_next = head_job.b1;
                has_next  = 1'b1;
            end
            else if (pick[2])
            begin
                sdone_next = 1'b1;
                err_next   = head_job.st_err;
            end

            if (pending != 3'b000)
            begin
                // retire the job on its final result, else mark the slot as sent
                if (final_pick)
                begin
                    pop       = 1'b1;
                    done_next = 3'b000;
                end
                else
                    done_next = done_reg | pick;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 3'b000;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        has_reg   <= has_next;
        sdone_reg <= sdone_next;
        err_reg   <= err_next;
        lor_reg   <= lor_next;
    end

    assign decoded.valid       = valid_reg;
    assign decoded.out_byte    = byte_reg;
    assign decoded.has_byte    = has_reg;
    assign decoded.string_done = sdone_reg;
    assign decoded.error_code  = err_reg;
    assign decoded.last_of_run = lor_reg;

endmodule

// File: design/unescape_string_decoder.sv
// The first result of a byte passes through the job queue and then the output register before
// it is offered. Input beats are taken one per cycle while the queue is not full; results leave
// at one beat per cycle from the output register while the sink takes them, and a byte gives
// 0 to 3 results. The job queue (QUEUE_DEPTH entries) absorbs those bursts; input stalls only when it is full.
// Reset (rst_n, asynchronous, active low) returns the decoder to plain mode with no error
// and empties the queue and output register at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// unescape_string_decoder
// Streaming decoder for C-style escaped strings, with a status beat per string.
// ---------------------------------------------------------------------------
`include "unescape_string_decoder_assert.svh"

module unescape_string_decoder
#(
    // job queue depth, at least 2
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    usd_in_if.sink    raw,
    usd_out_if.source decoded
);

    // Front: accepts raw beats, keeps escape mode, octal accumulator and the
    // sticky error, and turns every beat into a job of up to three results.
    // Back: drains jobs one result per cycle into the output register while that register
    // is empty or being taken, so each side stalls on its own with only the queue between them.
    usd_pkg::usd_job_t      push_job;
    usd_pkg::usd_job_t      head_job;
    usd_pkg::usd_q_status_t q_stat;
    logic                   q_push;
    logic                   q_pop;

    usd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_job (push_job)
    );

    // Beats that yield no result never enter the queue.
    usd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // The back end pops a job as it loads that job's final result.
    usd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .decoded  (decoded)
    );

    // A status beat always closes the run of results for its input.
    `USD_ASSERT_IMPLIES(a_status_is_last, clk, rst_n, decoded.valid && decoded.string_done, decoded.last_of_run && !decoded.has_byte, "status beat not final or carries a byte")
    // Byte beats never carry an error code.
    `USD_ASSERT_IMPLIES(a_byte_no_error, clk, rst_n, decoded.valid && decoded.has_byte, decoded.error_code == usd_pkg::ERR_NONE, "byte beat with error code")
    // A full queue must hold off the input side.
    `USD_ASSERT_IMPLIES(a_full_stalls, clk, rst_n, q_stat.full, !raw.ready, "input accepted into full queue")
    // A pushed job is visible to the back end in the next cycle.
    `USD_ASSERT_NEXT(a_push_seen, clk, rst_n, q_push, !q_stat.empty, "pushed job lost")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Escaped string decoder testbench: directed escapes, octal runs and errors,
// then random strings under three idling profiles, checked beat by beat.
// ---------------------------------------------------------------------------
module tb;

    // Character codes seen on the raw side.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ALL1   = 8'hFF;

    // Control codes produced by the letter escapes.
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam int unsigned OCT_MAX = 255;
    localparam logic [1:0]  OCT_LEN = 2'd3;

    // Characters that follow a backslash in a well-formed escape.
    localparam logic [7:0] ESC_SET [8] = '{CH_BSLASH, CH_APOS, CH_QUOTE, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 8;
    localparam int REPORT_CAP     = 50;

    typedef enum logic [1:0] {
        M_PLAIN = 2'd0,
        M_ESC   = 2'd1,
        M_OCT   = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0]    out_byte;
        logic          has_byte;
        logic          string_done;
        usd_pkg::err_t error_code;
        logic          last_of_run;
    } dec_result_t;

    logic clk;
    logic rst_n;

    usd_in_if  raw_if ();
    usd_out_if dec_if ();

    unescape_string_decoder dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_if),
        .decoded (dec_if)
    );

    // Decoder state as the predictor sees it.
    scan_mode_t    dec_mode  = M_PLAIN;
    logic [7:0]    oct_val   = 8'd0;
    logic [1:0]    oct_count = 2'd0;
    usd_pkg::err_t str_err   = usd_pkg::ERR_NONE;

    dec_result_t run_q[$];      // results of the beat being decoded
    dec_result_t decoded_q[$];  // results still awaited from the block

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    function automatic logic printable(logic [7:0] b);
        return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

    function automatic void push_result(logic [7:0] b, logic has, logic done,
                                        usd_pkg::err_t e);
        dec_result_t r;
        r.out_byte    = has ? b : 8'd0;
        r.has_byte    = has;
        r.string_done = done;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        run_q = {run_q, r};
    endfunction

    // A byte met outside any escape: backslash opens one, a trailing one is fatal.
    function automatic void plain_char(logic [7:0] b, logic last);
        if (b == CH_BSLASH)
        begin
            if (last)
                str_err = usd_pkg::ERR_TRAIL;
            else
                dec_mode = M_ESC;
        end
        else if (printable(b))
            push_result(b, 1'b1, 1'b0, usd_pkg::ERR_NONE);
        else
            str_err = usd_pkg::ERR_ILLEGAL;
    endfunction

    // Work out every result that one raw beat causes and queue them in order.
    function automatic void unescape_step(logic [7:0] b, logic last);
        int unsigned v;
        run_q.delete();
        if (str_err == usd_pkg::ERR_NONE)
        begin
            case (dec_mode)
                M_ESC:
                begin
                    dec_mode = M_PLAIN;
                    case (b)
                        CH_BSLASH, CH_APOS, CH_QUOTE:
                            push_result(b, 1'b1, 1'b0, usd_pkg::ERR_NONE);
                        CH_B: push_result(CTL_BS,  1'b1, 1'b0, usd_pkg::ERR_NONE);
                        CH_F: push_result(CTL_FF,  1'b1, 1'b0, usd_pkg::ERR_NONE);
                        CH_N: push_result(CTL_LF,  1'b1, 1'b0, usd_pkg::ERR_NONE);
                        CH_R: push_result(CTL_CR,  1'b1, 1'b0, usd_pkg::ERR_NONE);
                        CH_T: push_result(CTL_TAB, 1'b1, 1'b0, usd_pkg::ERR_NONE);
                        default:
                        begin
                            if (b >= CH_0 && b <= CH_7)
                            begin
                                oct_val   = b - CH_0;
                                oct_count = 2'd1;
                                dec_mode  = M_OCT;
                            end
                            else if (printable(b))
                                push_result(b, 1'b1, 1'b0, usd_pkg::ERR_NONE);
                            else
                                str_err = usd_pkg::ERR_ILLEGAL;
                        end
                    endcase
                end
                M_OCT:
                begin
                    if (b >= CH_0 && b <= CH_7)
                    begin
                        v = 32'(oct_val) * 8 + 32'(b - CH_0);
                        oct_count = oct_count + 2'd1;
                        if (oct_count >= OCT_LEN)
                        begin
                            // Third digit closes the run; an over-range value is fatal.
                            dec_mode  = M_PLAIN;
                            oct_count = 2'd0;
                            oct_val   = 8'd0;
                            if (v > OCT_MAX)
                                str_err = usd_pkg::ERR_OCTAL;
                            else
                                push_result(v[7:0], 1'b1, 1'b0, usd_pkg::ERR_NONE);
                        end
                        else
                            oct_val = v[7:0];
                    end
                    else
                    begin
                        // Short run: flush the octal byte, then decode the ender afresh.
                        push_result(oct_val, 1'b1, 1'b0, usd_pkg::ERR_NONE);
                        dec_mode  = M_PLAIN;
                        oct_val   = 8'd0;
                        oct_count = 2'd0;
                        plain_char(b, last);
                    end
                end
                default:
                begin
                    dec_mode = M_PLAIN;
                    plain_char(b, last);
                end
            endcase

            // String closed in the middle of an octal run: flush what was gathered.
            if (last && str_err == usd_pkg::ERR_NONE && dec_mode == M_OCT)
                push_result(oct_val, 1'b1, 1'b0, usd_pkg::ERR_NONE);
        end

        if (last)
        begin
            push_result(8'd0, 1'b0, 1'b1, str_err);
            dec_mode  = M_PLAIN;
            oct_val   = 8'd0;
            oct_count = 2'd0;
            str_err   = usd_pkg::ERR_NONE;
        end

        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last_of_run = 1'b1;
        foreach (run_q[i])
            decoded_q = {decoded_q, run_q[i]};
    endfunction

    // -----------------------------------------------------------------------
    // Sending side
    // -----------------------------------------------------------------------

    // Offer one raw beat after a random gap; predict its results once it is taken.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid          <= 1'b1;
        raw_if.in_byte        <= b;
        raw_if.last_in_string <= last;
        do
            @(posedge clk);
        while (!raw_if.ready);
        unescape_step(b, last);
    endtask

    // Send a whole string, flagging its final character.
    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], i == txt.len() - 1);
    endtask

    // Hold the sender off until every awaited result has been seen.
    task automatic wait_drain();
        raw_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Lowest and highest printable bytes pass straight through.
    task automatic test_plain_bounds();
        send_text(" ~");
    endtask

    // A letter escape, escaped quote and escaped backslash.
    task automatic test_escapes();
        send_text("\\n\\\"\\\\");
    endtask

    // Full runs at the top of the range and just past it, a run cut short by a
    // letter (three results from one beat) and a string ending inside a run.
    task automatic test_octal();
        send_text("\\377\\400");
        send_text("\\7A");
        send_text("\\1");
    endtask

    // Trailing backslash, then an illegal byte whose successor is dropped.
    task automatic test_errors();
        send_text("\\");
        send_beat(CH_NUL, 1'b0);
        send_beat(CH_ALL1, 1'b1);
    endtask

    // Mostly well-formed strings with random content; a few noise bytes, and a
    // random cut that can leave a dangling backslash or an open octal run.
    task automatic test_random_strings(input int unsigned n_items);
        logic [7:0]  s[$];
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        int unsigned ndig;
        sent = 0;
        while (sent < n_items)
        begin
            s.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            while (s.size() < len)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    s = {s, 8'($urandom_range(PRINT_LO, PRINT_HI))};
                else if (pick < 75)
                begin
                    s = {s, CH_BSLASH};
                    if ($urandom_range(3) != 0)
                        s = {s, ESC_SET[$urandom_range(7)]};
                    else
                        s = {s, 8'($urandom_range(PRINT_LO, PRINT_HI))};
                end
                else if (pick < 91)
                begin
                    s = {s, CH_BSLASH};
                    ndig = $urandom_range(1, 3);
                    repeat (ndig)
                        s = {s, 8'(CH_0 + 8'($urandom_range(7)))};
                end
                else
                    s = {s, 8'($urandom_range(255))};
            end
            while (s.size() > len)
                void'(s.pop_back());
            foreach (s[i])
                send_beat(s[i], i == s.size() - 1);
            sent += s.size();
            if ($urandom_range(15) == 0)
                wait_drain();
        end
    endtask

    // -----------------------------------------------------------------------
    // Checking side
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted result beat with the oldest prediction, then pick
    // the next cycle's ready at random.
    always @(posedge clk)
    begin : check_beat
        dec_result_t want;
        if (rst_n)
        begin
            if (dec_if.valid && dec_if.ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch("unexpected result beat", dec_if.out_byte, 8'd0);
                else
                begin
                    want = decoded_q.pop_front();
                    if (dec_if.out_byte !== want.out_byte)
                        report_mismatch("out_byte", dec_if.out_byte, want.out_byte);
                    if (dec_if.has_byte !== want.has_byte)
                        report_mismatch("has_byte", 8'(dec_if.has_byte), 8'(want.has_byte));
                    if (dec_if.string_done !== want.string_done)
                        report_mismatch("string_done", 8'(dec_if.string_done),
                                        8'(want.string_done));
                    if (dec_if.error_code !== want.error_code)
                        report_mismatch("error_code", 8'(dec_if.error_code),
                                        8'(want.error_code));
                    if (dec_if.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 8'(dec_if.last_of_run),
                                        8'(want.last_of_run));
                end
            end
            dec_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Count cycles with no beat on either side; a long run of them is a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((raw_if.valid && raw_if.ready) || (dec_if.valid && dec_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial
    begin
        // Initialise every input before the first edge, with reset held, then release reset.
        rst_n                 = 1'b0;
        raw_if.valid          = 1'b0;
        raw_if.in_byte        = 8'd0;
        raw_if.last_in_string = 1'b0;
        dec_if.ready          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Sparse sender, reluctant receiver: the job queue fills and input stalls.
        src_idle_pct = 32;
        snk_idle_pct = 68;
        test_plain_bounds();
        test_escapes();
        test_octal();
        test_errors();
        test_random_strings(110);
        wait_drain();

        // Reluctant sender, eager receiver: the queue mostly runs empty.
        src_idle_pct = 68;
        snk_idle_pct = 32;
        test_random_strings(110);

        // Back to back on both sides.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_strings(110);

        // Drain, then wait out the drain tail for any stray beat to show up.
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/usd_pkg.sv
design/usd_if.sv
design/usd_front.sv
design/usd_queue.sv
design/usd_back.sv
design/unescape_string_decoder.sv
tb/tb.sv
